[hdl/bls_pkg.sv]
`timescale 1ns / 1ps

package bls_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int ADDR_W    = 22;
  localparam int COLOR_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

endpackage

[hdl/bls_if.sv]
`timescale 1ns / 1ps

interface bls_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [bls_pkg::COLOR_W-1:0]  color;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, color, input ready);
  modport sink (input valid, cmd, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface bls_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         pixel_valid;
  logic                         write_enable;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [bls_pkg::ADDR_W-1:0]   pixel_addr;
  logic [bls_pkg::COLOR_W-1:0]  pixel_color;
  logic                         last;

  modport source (output valid, pixel_valid, write_enable, pixel_x, pixel_y, pixel_addr,
                  pixel_color, last, input ready);
  modport sink (input valid, pixel_valid, write_enable, pixel_x, pixel_y, pixel_addr,
                pixel_color, last, output ready);
endinterface

[hdl/bls_clip.sv]
`timescale 1ns / 1ps

module bls_clip #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0]   x,
  input  logic signed [COORD_BITS-1:0]   y,
  input  logic [bls_pkg::CFG_W-1:0]      screen_width,
  input  logic [bls_pkg::CFG_W-1:0]      screen_height,
  output logic                           on_screen,
  output logic [bls_pkg::ADDR_W-1:0]     addr
);

  localparam int CMPW = (COORD_BITS > bls_pkg::CFG_W) ? COORD_BITS : bls_pkg::CFG_W;
  localparam int PW   = COORD_BITS + bls_pkg::CFG_W;
  localparam int MW   = (PW > bls_pkg::ADDR_W) ? PW : bls_pkg::ADDR_W;

  logic [PW-1:0] prod;
  logic [MW-1:0] sum;

  always_comb begin
    on_screen = !x[COORD_BITS-1] && !y[COORD_BITS-1] &&
                (CMPW'($unsigned(x)) < CMPW'(screen_width)) &&
                (CMPW'($unsigned(y)) < CMPW'(screen_height));
    prod      = PW'($unsigned(y)) * PW'(screen_width);
    sum       = MW'(prod) + MW'($unsigned(x));
    addr      = on_screen ? sum[bls_pkg::ADDR_W-1:0] : '0;
  end

endmodule

[hdl/bls_walker.sv]
`timescale 1ns / 1ps

module bls_walker #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [COORD_BITS-1:0]  x_start,
  input  logic signed [COORD_BITS-1:0]  y_start,
  input  logic signed [COORD_BITS-1:0]  x_end,
  input  logic signed [COORD_BITS-1:0]  y_end,
  input  logic [bls_pkg::COLOR_W-1:0]   color,
  input  logic [bls_pkg::CFG_W-1:0]     screen_width,
  input  logic [bls_pkg::CFG_W-1:0]     screen_height,
  input  logic                          room,
  output logic                          push,
  output logic                          pixel_valid,
  output logic                          write_enable,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic [bls_pkg::ADDR_W-1:0]    pixel_addr,
  output logic [bls_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          last
);

  localparam int CB  = COORD_BITS;
  localparam int CB1 = COORD_BITS + 1;
  localparam int EB  = COORD_BITS + 3;

  // input register
  logic                        s1_valid;
  logic                        s1_cmd;
  logic signed [CB-1:0]        s1_xs, s1_ys, s1_xe, s1_ye;
  logic [bls_pkg::COLOR_W-1:0] s1_color;

  // line state
  logic                        active;
  logic                        steep;
  logic signed [CB-1:0]        cur_major, cur_minor, end_major;
  logic signed [EB-1:0]        err_term;
  logic [CB-1:0]               delta_major, delta_minor;
  logic                        minor_down;
  logic [bls_pkg::COLOR_W-1:0] line_color;

  logic                 accept;
  logic signed [CB:0]   dx, dy, dmin_s, dmaj_s;
  logic [CB-1:0]        adx, ady, dmin_abs, dmaj;
  logic                 ld_steep, swap;
  logic signed [CB-1:0] ma0, mi0, ma1, mi1, sma0, smi0, sma1, smi1;
  logic signed [EB-1:0] ld_err;

  logic signed [CB-1:0] px, py;
  logic                 is_last, err_pos;
  logic signed [EB-1:0] err_next;
  logic signed [CB-1:0] minor_next;
  logic                 on_screen;
  logic [bls_pkg::ADDR_W-1:0] addr;

  assign in_ready = !s1_valid || room;
  assign accept   = in_valid && in_ready;
  assign push     = s1_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_xs    <= x_start;
      s1_ys    <= y_start;
      s1_xe    <= x_end;
      s1_ye    <= y_end;
      s1_color <= color;
    end
  end

  // line setup
  always_comb begin
    dx       = CB1'(s1_xe) - CB1'(s1_xs);
    dy       = CB1'(s1_ye) - CB1'(s1_ys);
    adx      = dx[CB] ? CB'(-dx) : CB'(dx);
    ady      = dy[CB] ? CB'(-dy) : CB'(dy);
    ld_steep = !(ady < adx);
    ma0      = ld_steep ? s1_ys : s1_xs;
    mi0      = ld_steep ? s1_xs : s1_ys;
    ma1      = ld_steep ? s1_ye : s1_xe;
    mi1      = ld_steep ? s1_xe : s1_ye;
    swap     = ma0 > ma1;
    sma0     = swap ? ma1 : ma0;
    smi0     = swap ? mi1 : mi0;
    sma1     = swap ? ma0 : ma1;
    smi1     = swap ? mi0 : mi1;
    dmaj_s   = CB1'(sma1) - CB1'(sma0);
    dmaj     = CB'(dmaj_s);
    dmin_s   = CB1'(smi1) - CB1'(smi0);
    dmin_abs = dmin_s[CB] ? CB'(-dmin_s) : CB'(dmin_s);
    ld_err   = $signed({2'b00, dmin_abs, 1'b0}) - $signed({3'b000, dmaj});
  end

  // step
  always_comb begin
    px         = steep ? cur_minor : cur_major;
    py         = steep ? cur_major : cur_minor;
    is_last    = cur_major >= end_major;
    err_pos    = !err_term[EB-1] && (err_term != '0);
    err_next   = err_term + $signed({2'b00, delta_minor, 1'b0});
    minor_next = cur_minor;
    if (err_pos) begin
      err_next   = err_next - $signed({2'b00, delta_major, 1'b0});
      minor_next = minor_down ? cur_minor - CB'(1) : cur_minor + CB'(1);
    end
  end

  bls_clip #(
    .COORD_BITS(COORD_BITS)
  ) u_clip (
    .x            (px),
    .y            (py),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .on_screen    (on_screen),
    .addr         (addr)
  );

  always_comb begin
    pixel_valid  = 1'b0;
    write_enable = 1'b0;
    pixel_x      = '0;
    pixel_y      = '0;
    pixel_addr   = '0;
    pixel_color  = '0;
    last         = 1'b0;
    if (s1_cmd == bls_pkg::CMD_STEP && active) begin
      pixel_valid  = 1'b1;
      write_enable = on_screen;
      pixel_x      = px;
      pixel_y      = py;
      pixel_addr   = addr;
      pixel_color  = line_color;
      last         = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (push) begin
      if (s1_cmd == bls_pkg::CMD_LOAD) begin
        active <= 1'b1;
      end else if (active && is_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (s1_cmd == bls_pkg::CMD_LOAD) begin
        steep       <= ld_steep;
        cur_major   <= sma0;
        cur_minor   <= smi0;
        end_major   <= sma1;
        err_term    <= ld_err;
        delta_major <= dmaj;
        delta_minor <= dmin_abs;
        minor_down  <= dmin_s[CB];
        line_color  <= s1_color;
      end else if (active && !is_last) begin
        cur_major <= cur_major + CB'(1);
        cur_minor <= minor_next;
        err_term  <= err_next;
      end
    end
  end

endmodule

[hdl/bls_out_buf.sv]
`timescale 1ns / 1ps

module bls_out_buf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   count_next;
  logic         pop;

  assign room      = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign dout      = mem[rd_ptr];

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[hdl/bresenham_line_stepper.sv]
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// cmds      in   cmds.valid/ready     cmd, x_start, y_start, x_end, y_end, color
// pixels    out  pixels.valid/ready   pixel_valid, write_enable, pixel_x, pixel_y,
//                                     pixel_addr, pixel_color, last
// cfg       in   cfg_we               cfg_index, cfg_data
//
// One word per cycle in and out while pixels is ready; a word's result passes the input
// register, one pass of step or setup logic and the result queue before it leaves.
// Reset clears the line, the input register and the result queue; width resets to 640,
// height to 480. The result queue holds two words, so cmds keeps taking words while one waits.

module bresenham_line_stepper #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bls_pkg::CFG_W-1:0]       cfg_data,
  bls_cmd_if.sink                         cmds,
  bls_pix_if.source                       pixels
);

  localparam int RW = 3 + 2 * COORD_BITS + bls_pkg::ADDR_W + bls_pkg::COLOR_W;

  logic [bls_pkg::CFG_W-1:0] screen_width;
  logic [bls_pkg::CFG_W-1:0] screen_height;

  logic                        room;
  logic                        push;
  logic                        pixel_valid;
  logic                        write_enable;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [bls_pkg::ADDR_W-1:0]  pixel_addr;
  logic [bls_pkg::COLOR_W-1:0] pixel_color;
  logic                        last;
  logic [RW-1:0]               res_word;
  logic [RW-1:0]               buf_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= bls_pkg::SCREEN_WIDTH_RST;
      screen_height <= bls_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bls_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        bls_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bls_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cmds.valid),
    .in_ready     (cmds.ready),
    .cmd          (cmds.cmd),
    .x_start      (cmds.x_start),
    .y_start      (cmds.y_start),
    .x_end        (cmds.x_end),
    .y_end        (cmds.y_end),
    .color        (cmds.color),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .room         (room),
    .push         (push),
    .pixel_valid  (pixel_valid),
    .write_enable (write_enable),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_addr   (pixel_addr),
    .pixel_color  (pixel_color),
    .last         (last)
  );

  assign res_word = {pixel_valid, write_enable, pixel_x, pixel_y, pixel_addr, pixel_color,
                     last};

  bls_out_buf #(
    .W(RW)
  ) u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (res_word),
    .room     (room),
    .out_valid(pixels.valid),
    .out_ready(pixels.ready),
    .dout     (buf_word)
  );

  assign {pixels.pixel_valid, pixels.write_enable, pixels.pixel_x, pixels.pixel_y,
          pixels.pixel_addr, pixels.pixel_color, pixels.last} = buf_word;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> room)
    else $error("result queue overflow");

  a_we_needs_pixel: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.write_enable) |-> pixels.pixel_valid)
    else $error("write enable without a pixel");

  a_empty_word_zero: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && !pixels.pixel_valid) |->
      (!pixels.last && pixels.pixel_color == '0 && pixels.pixel_addr == '0 &&
       pixels.pixel_x == '0 && pixels.pixel_y == '0))
    else $error("non-pixel word carries data");

  a_addr_clipped: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && !pixels.write_enable) |-> pixels.pixel_addr == '0)
    else $error("clipped pixel carries an address");

endmodule
